>>> sv/rbap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbap_pkg: shared constants and types
// Frame geometry, request codes and the memory request struct.
// ----------------------------------------------------------------------------
package rbap_pkg;

  localparam int FRM_COLS     = 128;
  localparam int FRM_ROWS     = 128;
  localparam int MAX_TILE     = 16;
  localparam int COL_W        = $clog2(FRM_COLS);
  localparam int ROW_W        = $clog2(FRM_ROWS);
  localparam int ADDR_W       = COL_W + ROW_W;
  localparam int CNT_W        = $clog2(MAX_TILE * MAX_TILE + 1);
  localparam int SUM_W        = 8 + CNT_W;
  localparam logic [4:0] TILE_SIZE_RESET = 5'd15;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_PIX   = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // memory access request from sequencer
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [23:0]       wdata;
  } mem_req_t;

endpackage

>>> sv/rbap_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbap_store: pixel store
// Single-port frame memory, registered read data.
// ----------------------------------------------------------------------------
module rbap_store (
  input  logic              clk,
  input  rbap_pkg::mem_req_t req,
  output logic [23:0]       rdata
);

  logic [23:0] mem [0:(1 << rbap_pkg::ADDR_W) - 1];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

>>> sv/rbap_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbap_divider: shared restoring divider
// One quotient bit per cycle, used in turn for each color channel.
// ----------------------------------------------------------------------------
module rbap_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rbap_pkg::SUM_W-1:0] dividend,
  input  logic [rbap_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [7:0]                 quotient
);

  localparam int STEP_W = $clog2(rbap_pkg::SUM_W + 1);

  logic [rbap_pkg::SUM_W-1:0] quo;
  logic [rbap_pkg::CNT_W:0]   rem;
  logic [rbap_pkg::CNT_W-1:0] dvs;
  logic [STEP_W-1:0]          steps;
  logic                       busy;
  logic [rbap_pkg::CNT_W:0]   trial;

  always_comb begin
    trial = {rem[rbap_pkg::CNT_W-1:0], quo[rbap_pkg::SUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
        steps <= STEP_W'(rbap_pkg::SUM_W);
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[rbap_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[rbap_pkg::SUM_W-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo[7:0];

endmodule

>>> sv/region_block_average_pixelate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_block_average_pixelate_top: mosaic pixelation over a pixel store
// Pixel write/read and block-average pixelate of a rectangle.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      request word
//  m_axis    out  m_axis_tvalid/tready      response word
//  cfg       in   cfg_valid/cfg_ready       tile_size
//
// Write: accept, then response. Read: accept, the registered store read
// (S_RD, S_RDW), then response. Pixelate: per in-frame tile, sum its pixels,
// divide each of the three channel sums in the shared divider, write the
// average back, then step to the next tile; plus accept and response states.
// Reset clears control only; the pixel store holds junk until written.
// s_axis_tready is low from acceptance until the response word is taken.
// ----------------------------------------------------------------------------
module region_block_average_pixelate_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[1:0], x_pos[8:2], y_pos[15:9], rect_width[22:16],
  // rect_height[29:23], in_blue[37:30], in_green[45:38], in_red[53:46]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_blue[7:0], out_green[15:8], out_red[23:16], status[24]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int CW = rbap_pkg::COL_W;
  localparam int RW = rbap_pkg::ROW_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_RDW, S_TILE, S_SUM, S_SUMW, S_DIV, S_DIVW, S_WB, S_NEXT, S_OUT
  } state_t;

  state_t state;
  logic [4:0] tile_size;

  logic [7:0]  x0, y0, xe, ye;  // corner and inclusive end of tile starts
  logic [7:0]  tx, ty;          // tile start
  logic [7:0]  ts;
  logic [7:0]  c1, r1;          // clipped tile end (exclusive)
  logic [7:0]  cc, rr;          // walking pixel
  logic [rbap_pkg::SUM_W-1:0] sums [0:2];
  logic [rbap_pkg::CNT_W-1:0] cnt;
  logic [1:0]  ch;
  logic [23:0] avg;
  logic [23:0] out_pix;
  logic        status;
  logic        pend;            // read data arriving this cycle
  logic        req_off_frame;   // start coordinate beyond the frame

  rbap_pkg::mem_req_t mreq;
  logic [23:0] rdata;
  logic        dstart, ddone;
  logic [7:0]  dq;

  rbap_store u_store (.clk(clk), .req(mreq), .rdata(rdata));

  rbap_divider u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(sums[ch]),
    .divisor(cnt), .done(ddone), .quotient(dq)
  );

  assign req_off_frame = ({1'b0, s_axis_tdata[8:2]} >= 8'(rbap_pkg::FRM_COLS)) ||
                         ({1'b0, s_axis_tdata[15:9]} >= 8'(rbap_pkg::FRM_ROWS));

  logic [7:0] t_c1, t_r1, nx, ny;
  always_comb begin
    t_c1 = (9'(tx) + 9'(ts) > 9'(rbap_pkg::FRM_COLS)) ?
           8'(rbap_pkg::FRM_COLS) : 8'(tx + ts);
    t_r1 = (9'(ty) + 9'(ts) > 9'(rbap_pkg::FRM_ROWS)) ?
           8'(rbap_pkg::FRM_ROWS) : 8'(ty + ts);
    nx = tx + ts;
    ny = ty + ts;
  end

  // memory request mux
  always_comb begin
    mreq = '0;
    mreq.addr = {rr[RW-1:0], cc[CW-1:0]};
    unique case (state)
      S_IDLE: begin
        mreq.addr = {s_axis_tdata[9 +: RW], s_axis_tdata[2 +: CW]};
        if (s_axis_tvalid && s_axis_tready &&
            s_axis_tdata[1:0] == rbap_pkg::REQ_WRITE && !req_off_frame) begin
          mreq.wr = 1'b1;
        end
        if (s_axis_tvalid && s_axis_tready &&
            s_axis_tdata[1:0] == rbap_pkg::REQ_READ) begin
          mreq.rd = 1'b1;
        end
        mreq.wdata = s_axis_tdata[53:30];
      end
      S_SUM:   mreq.rd = 1'b1;
      S_WB: begin
        mreq.wr = 1'b1;
        mreq.wdata = avg;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign dstart = (state == S_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tile_size <= rbap_pkg::TILE_SIZE_RESET;
      m_axis_tvalid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) tile_size <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            x0 <= {1'b0, s_axis_tdata[8:2]};
            y0 <= {1'b0, s_axis_tdata[15:9]};
            xe <= 8'(s_axis_tdata[8:2]) + 8'(s_axis_tdata[22:16]);
            ye <= 8'(s_axis_tdata[15:9]) + 8'(s_axis_tdata[29:23]);
            tx <= {1'b0, s_axis_tdata[8:2]};
            ty <= {1'b0, s_axis_tdata[15:9]};
            ts <= (tile_size == 5'd0) ? 8'd1 :
                  (tile_size > 5'(rbap_pkg::MAX_TILE)) ? 8'(rbap_pkg::MAX_TILE) :
                  8'(tile_size);
            out_pix <= '0;
            status <= 1'b0;
            if (s_axis_tdata[1:0] == rbap_pkg::REQ_NONE) begin
              state <= S_OUT;
              m_axis_tvalid <= 1'b1;
            end else if (req_off_frame) begin
              status <= 1'b1;
              state <= S_OUT;
              m_axis_tvalid <= 1'b1;
            end else if (s_axis_tdata[1:0] == rbap_pkg::REQ_READ) begin
              state <= S_RD;
            end else if (s_axis_tdata[1:0] == rbap_pkg::REQ_PIX) begin
              state <= S_TILE;
            end else begin
              state <= S_OUT;
              m_axis_tvalid <= 1'b1;
            end
          end
        end
        S_RD:  state <= S_RDW;
        S_RDW: begin
          out_pix <= rdata;
          state <= S_OUT;
          m_axis_tvalid <= 1'b1;
        end
        S_TILE: begin
          // tile starts are within the 8-bit sum range; starts past the frame are skipped, the frame edge clips
          if (tx >= 8'(rbap_pkg::FRM_COLS) || ty >= 8'(rbap_pkg::FRM_ROWS)) begin
            state <= S_NEXT;
          end else begin
            c1 <= t_c1;
            r1 <= t_r1;
            cc <= tx;
            rr <= ty;
            sums[0] <= '0;
            sums[1] <= '0;
            sums[2] <= '0;
            cnt <= '0;
            pend <= 1'b0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          pend <= 1'b1;
          if (pend) begin
            sums[0] <= sums[0] + rbap_pkg::SUM_W'(rdata[7:0]);
            sums[1] <= sums[1] + rbap_pkg::SUM_W'(rdata[15:8]);
            sums[2] <= sums[2] + rbap_pkg::SUM_W'(rdata[23:16]);
            cnt <= cnt + 1'b1;
          end
          if (cc + 8'd1 >= c1) begin
            cc <= tx;
            if (rr + 8'd1 >= r1) state <= S_SUMW;
            else rr <= rr + 8'd1;
          end else begin
            cc <= cc + 8'd1;
          end
        end
        S_SUMW: begin
          pend <= 1'b0;
          sums[0] <= sums[0] + rbap_pkg::SUM_W'(rdata[7:0]);
          sums[1] <= sums[1] + rbap_pkg::SUM_W'(rdata[15:8]);
          sums[2] <= sums[2] + rbap_pkg::SUM_W'(rdata[23:16]);
          cnt <= cnt + 1'b1;
          ch <= 2'd0;
          state <= S_DIV;
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: begin
          if (ddone) begin
            avg[8*ch +: 8] <= dq;
            if (ch == 2'd2) begin
              cc <= tx;
              rr <= ty;
              state <= S_WB;
            end else begin
              ch <= ch + 2'd1;
              state <= S_DIV;
            end
          end
        end
        S_WB: begin
          if (cc + 8'd1 >= c1) begin
            cc <= tx;
            if (rr + 8'd1 >= r1) state <= S_NEXT;
            else rr <= rr + 8'd1;
          end else begin
            cc <= cc + 8'd1;
          end
        end
        S_NEXT: begin
          // inner loop over rows, outer over columns
          if (9'(ty) + 9'(ts) <= 9'(ye) && ny < 8'(rbap_pkg::FRM_ROWS)) begin
            ty <= ny;
            state <= S_TILE;
          end else if (9'(tx) + 9'(ts) <= 9'(xe) && nx < 8'(rbap_pkg::FRM_COLS)) begin
            tx <= nx;
            ty <= y0;
            state <= S_TILE;
          end else begin
            state <= S_OUT;
            m_axis_tvalid <= 1'b1;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, status, out_pix};

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while response pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("response dropped");
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && status) |-> out_pix == 24'd0) else $error("bad status word");

endmodule

>>> verif/region_block_average_pixelate_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_block_average_pixelate_top_tb: self-checking bench for the mosaic block
// Loads two corner blocks, then runs directed and random write, read,
// pixelate and unused requests under several tile sizes and idle patterns.
// Each response word is checked against a local frame model.
// ----------------------------------------------------------------------------
module region_block_average_pixelate_top_tb;

  localparam int COLS = rbap_pkg::FRM_COLS;
  localparam int ROWS = rbap_pkg::FRM_ROWS;

  typedef struct {
    logic [1:0] kind;
    logic [6:0] col;
    logic [6:0] row;
    logic [6:0] wid;
    logic [6:0] hgt;
    logic [7:0] blu;
    logic [7:0] grn;
    logic [7:0] red;
  } pix_req_t;

  typedef struct {
    logic [7:0] blu;
    logic [7:0] grn;
    logic [7:0] red;
    logic       stat;
  } pix_rsp_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  region_block_average_pixelate_top uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // local frame copy, written map and tile setting
  logic [23:0] frame_mem [COLS*ROWS];
  bit          written [COLS*ROWS];
  int          wr_list [$];
  logic [4:0]  tile_reg;
  pix_rsp_t    rsp_q [$];

  int src_idle_pct;
  int snk_stall_pct;
  int n_sent, n_checked, n_errors, n_pix;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("region_block_average_pixelate_top_tb: FAIL");
    $finish;
  end

  function automatic int tile_edge();
    if (tile_reg == 0) return 1;
    if (tile_reg > rbap_pkg::MAX_TILE) return rbap_pkg::MAX_TILE;
    return tile_reg;
  endfunction

  // true when every in-frame pixel a pixelate would touch is written
  function automatic bit tiles_written(int x, int y, int w, int h, int ts);
    for (int tx = x; tx <= x + w; tx += ts)
      for (int ty = y; ty <= y + h; ty += ts)
        for (int r = ty; r < ty + ts && r < ROWS; r++)
          for (int c = tx; c < tx + ts && c < COLS; c++)
            if (!written[r*COLS + c]) return 1'b0;
    return 1'b1;
  endfunction

  // mean of one clipped tile written back over it
  function automatic void mosaic_tile(int c0, int r0, int ts);
    int c1, r1, n, sb, sg, sr;
    logic [23:0] px, avg;
    c1 = (c0 + ts > COLS) ? COLS : c0 + ts;
    r1 = (r0 + ts > ROWS) ? ROWS : r0 + ts;
    if (c0 >= c1 || r0 >= r1) return;
    n = 0; sb = 0; sg = 0; sr = 0;
    for (int r = r0; r < r1; r++)
      for (int c = c0; c < c1; c++) begin
        px = frame_mem[r*COLS + c];
        sb += px[7:0]; sg += px[15:8]; sr += px[23:16];
        n++;
      end
    avg = {8'(sr / n), 8'(sg / n), 8'(sb / n)};
    for (int r = r0; r < r1; r++)
      for (int c = c0; c < c1; c++)
        frame_mem[r*COLS + c] = avg;
  endfunction

  function automatic pix_rsp_t apply_req(pix_req_t q);
    pix_rsp_t e;
    int ts, a;
    logic [23:0] px;
    e = '{8'd0, 8'd0, 8'd0, 1'b0};
    a = q.row*COLS + q.col;
    // 7-bit coordinates always land inside a 128x128 frame
    case (q.kind)
      rbap_pkg::REQ_WRITE: begin
        frame_mem[a] = {q.red, q.grn, q.blu};
        if (!written[a]) begin
          written[a] = 1'b1;
          wr_list.push_back(a);
        end
      end
      rbap_pkg::REQ_READ: begin
        px = frame_mem[a];
        e.blu = px[7:0]; e.grn = px[15:8]; e.red = px[23:16];
      end
      rbap_pkg::REQ_PIX: begin
        ts = tile_edge();
        for (int tx = q.col; tx <= q.col + q.wid; tx += ts)
          for (int ty = q.row; ty <= q.row + q.hgt; ty += ts)
            mosaic_tile(tx, ty, ts);
      end
      default: ;
    endcase
    return e;
  endfunction

  // present one request word; valid stays high into the next call
  task automatic send_req(pix_req_t q);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, q.red, q.grn, q.blu, q.hgt, q.wid, q.row, q.col, q.kind};
    do @(posedge clk); while (!s_axis_tready);
    rsp_q.push_back(apply_req(q));
    n_sent++;
    if (q.kind == rbap_pkg::REQ_PIX) n_pix++;
  endtask

  task automatic src_stop();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_tile_size(logic [4:0] v);
    src_stop();
    wait_drain();
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tile_reg = v;
  endtask

  function automatic pix_req_t mk(logic [1:0] k, int c, int r, int w = 0, int h = 0,
                                  logic [23:0] rgb = 24'd0);
    pix_req_t q;
    q.kind = k; q.col = 7'(c); q.row = 7'(r); q.wid = 7'(w); q.hgt = 7'(h);
    q.red = rgb[23:16]; q.grn = rgb[15:8]; q.blu = rgb[7:0];
    return q;
  endfunction

  // response checker
  always @(posedge clk) begin
    pix_rsp_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected response word %h", $time, m_axis_tdata);
        n_errors++;
      end else begin
        e = rsp_q.pop_front();
        n_checked++;
        if (m_axis_tdata[7:0] !== e.blu || m_axis_tdata[15:8] !== e.grn ||
            m_axis_tdata[23:16] !== e.red || m_axis_tdata[24] !== e.stat) begin
          $display("%0t: mismatch expected b=%h g=%h r=%h st=%b actual %h",
                   $time, e.blu, e.grn, e.red, e.stat, m_axis_tdata);
          n_errors++;
        end
      end
    end
  end

  // sink back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // load the top-left 16x16 block and the bottom-right 8x8 corner;
  // reads and tiles are kept to written pixels
  task automatic test_fill_frame();
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        send_req(mk(rbap_pkg::REQ_WRITE, c, r, $urandom_range(127), $urandom_range(127),
                    24'($urandom)));
    for (int r = ROWS - 8; r < ROWS; r++)
      for (int c = COLS - 8; c < COLS; c++)
        send_req(mk(rbap_pkg::REQ_WRITE, c, r, $urandom_range(127), $urandom_range(127),
                    24'($urandom)));
  endtask

  task automatic test_directed();
    send_req(mk(rbap_pkg::REQ_WRITE, 0, 0, 0, 0, 24'h000000));
    send_req(mk(rbap_pkg::REQ_WRITE, 127, 127, 127, 127, 24'hFFFFFF));
    send_req(mk(rbap_pkg::REQ_WRITE, 127, 0, 5, 9, 24'h123456));
    send_req(mk(rbap_pkg::REQ_WRITE, 0, 127, 0, 0, 24'hABCDEF));
    send_req(mk(rbap_pkg::REQ_READ, 0, 0));
    send_req(mk(rbap_pkg::REQ_READ, 127, 127));
    send_req(mk(rbap_pkg::REQ_READ, 127, 0, 127, 127, 24'hFFFFFF));
    send_req(mk(rbap_pkg::REQ_READ, 0, 127));
    send_req(mk(rbap_pkg::REQ_NONE, 127, 127, 127, 127, 24'hFFFFFF));
    send_req(mk(rbap_pkg::REQ_NONE, 0, 0));
    // reset tile size (15), one tile clipped at bottom-right corner
    send_req(mk(rbap_pkg::REQ_PIX, 120, 120, 0, 0));
    send_req(mk(rbap_pkg::REQ_READ, 127, 127));
    // tile starts past the frame are skipped
    send_req(mk(rbap_pkg::REQ_PIX, 127, 127, 127, 127));
    send_req(mk(rbap_pkg::REQ_READ, 127, 127));
    write_tile_size(5'd16);
    send_req(mk(rbap_pkg::REQ_PIX, 0, 0, 15, 15));        // one full tile
    send_req(mk(rbap_pkg::REQ_READ, 5, 9));
    send_req(mk(rbap_pkg::REQ_READ, 127, 0));
    write_tile_size(5'd0);                               // acts as one
    send_req(mk(rbap_pkg::REQ_PIX, 10, 10, 2, 1));
    send_req(mk(rbap_pkg::REQ_READ, 11, 11));
    write_tile_size(5'd31);                              // saturates
    send_req(mk(rbap_pkg::REQ_PIX, 121, 122, 20, 5));
    send_req(mk(rbap_pkg::REQ_READ, 125, 124));
    write_tile_size(5'd1);
    send_req(mk(rbap_pkg::REQ_PIX, 5, 6, 0, 0));
    send_req(mk(rbap_pkg::REQ_READ, 5, 6));
  endtask

  task automatic test_random(int n_req, logic [4:0] tsz, int s_idle, int k_stall);
    pix_req_t q;
    int pick, ts, a;
    write_tile_size(tsz);
    src_idle_pct  = s_idle;
    snk_stall_pct = k_stall;
    ts = tile_edge();
    for (int i = 0; i < n_req; i++) begin
      pick = $urandom_range(99);
      q = mk(rbap_pkg::REQ_WRITE, $urandom_range(127), $urandom_range(127),
             $urandom_range(127), $urandom_range(127), 24'($urandom));
      if (pick >= 40 && pick < 75) begin
        a = wr_list[$urandom_range(wr_list.size() - 1)];
        q.kind = rbap_pkg::REQ_READ;
        q.col = 7'(a % COLS);
        q.row = 7'(a / COLS);
      end else if (pick >= 75 && pick < 88) begin
        q.kind = rbap_pkg::REQ_PIX;
        q.col = 7'($urandom_range(15));
        q.row = 7'($urandom_range(15));
        q.wid = 7'($urandom_range(2*ts));
        q.hgt = 7'($urandom_range(2*ts));
        if (!tiles_written(q.col, q.row, q.wid, q.hgt, ts)) begin
          // corner starts clip inside the loaded corner block
          q.col = 7'(COLS - 8 + $urandom_range(7));
          q.row = 7'(ROWS - 8 + $urandom_range(7));
          q.wid = 7'($urandom_range(127));
          q.hgt = 7'($urandom_range(127));
        end
      end else if (pick >= 88) begin
        q.kind = rbap_pkg::REQ_NONE;
      end
      send_req(q);
      if (i == n_req / 2 && s_idle == 0) begin
        src_stop();
        wait_drain();                                    // sender holds off fully
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    n_sent = 0; n_checked = 0; n_errors = 0; n_pix = 0;
    tile_reg = rbap_pkg::TILE_SIZE_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_frame();
    test_directed();
    test_random(55, 5'd16, 0, 0);
    test_random(55, 5'd0, 78, 0);
    test_random(55, 5'd31, 0, 78);
    test_random(55, 5'($urandom_range(1, 16)), 36, 36);

    src_stop();
    wait_drain();
    repeat (50) @(posedge clk);
    $display("Covered block loads, reads, %0d pixelates and unused requests over tile",
             n_pix);
    $display("sizes 0..31 and four idle patterns: %0d requests, %0d responses checked",
             n_sent, n_checked);
    if (n_errors == 0 && rsp_q.size() == 0) begin
      $display("region_block_average_pixelate_top_tb: PASS");
    end else begin
      $display("region_block_average_pixelate_top_tb: FAIL");
    end
    $finish;
  end

endmodule
